// File: src/bgryuv_pkg.sv
// Shared types and fixed constants of the BGR to YUV frame writer.
// Depends on nothing; imported by the top level.
package bgryuv_pkg;

	localparam int ADDR_W       = 26;
	localparam int LUMA_IDX_W   = 24;
	localparam int CHROMA_IDX_W = 22;
	localparam int SIZE_REG_W   = 13;
	localparam int FMT_W        = 3;
	localparam int CFG_IDX_W    = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// Output layout codes
	localparam logic [FMT_W-1:0] FMT_NV12 = 3'd0;
	localparam logic [FMT_W-1:0] FMT_NV21 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_I420 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_YV12 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_YUYV = 3'd4;
	localparam logic [FMT_W-1:0] FMT_UYVY = 3'd5;
	localparam logic [FMT_W-1:0] FMT_P444 = 3'd6;

	// Reset values of the registers
	localparam logic [FMT_W-1:0]      RST_PIXEL_FORMAT = FMT_NV12;
	localparam logic [SIZE_REG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
	localparam logic [SIZE_REG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

	// Conversion coefficients in thousandths
	localparam int K_R_MILLI = 299;
	localparam int K_G_MILLI = 587;
	localparam int K_B_MILLI = 114;
	localparam int K_U_MILLI = 565;
	localparam int K_V_MILLI = 713;
	localparam int CHROMA_OFFSET = 128;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] byte_address;
		logic [7:0]        data_byte;
		logic              last_of_pixel;
		logic              frame_done;
	} result_t;

endpackage

// File: src/bgr_to_yuv_frame_writer_unit.sv
// BGR to YUV frame writer: converts raster-order BGR pixels into byte writes
// for NV12, NV21, I420, YV12, YUYV, UYVY or planar 4:4:4. Uses bgryuv_pkg.

// Each accepted pixel runs ten sequencer steps through one shared signed
// multiplier (three luma products, the frame area, the chroma row base and
// the two chroma products), then issues its byte writes one per cycle unless
// the write side stalls: one write, or three when chroma is sampled at that
// pixel. pixel_ready is low from acceptance until the pixel's last write is
// loaded and high only between pixels, so a new pixel waits until the last one
// is through. The write channel has its own output register, so the final write
// of one pixel may wait while the next pixel is already being converted.
// Configuration writes are always taken; a write to one of the three registers
// restarts the frame at column 0, row 0. There is no clearing pass after reset.
module bgr_to_yuv_frame_writer_unit #(
	parameter int MAX_WIDTH       = 4096,
	parameter int MAX_HEIGHT      = 4096,
	parameter int COEFF_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pixel_valid,
	output logic                                 pixel_ready,
	input  bgryuv_pkg::pixel_t                   pixel,
	output logic                                 mem_valid,
	input  logic                                 mem_ready,
	output bgryuv_pkg::result_t                  mem,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bgryuv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bgryuv_pkg::SIZE_REG_W-1:0]    cfg_data
);
	import bgryuv_pkg::*;

	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int H_W    = $clog2(MAX_HEIGHT + 1);
	localparam int CX_W   = $clog2(MAX_WIDTH);
	localparam int RY_W   = $clog2(MAX_HEIGHT);
	localparam int W_MAX  = (MAX_WIDTH / 4) * 4;
	localparam int H_MAX  = (MAX_HEIGHT / 4) * 4;
	localparam int A_W    = ((W_W > 9) ? W_W : 9) + 1;
	localparam int B_W    = ((COEFF_FRAC_BITS + 1 > H_W) ? COEFF_FRAC_BITS + 1 : H_W) + 1;
	localparam int P_W    = A_W + B_W;
	localparam int AREA_W = W_W + H_W;
	localparam int CALC_W = (AREA_W + 2 > ADDR_W + 1) ? AREA_W + 2 : ADDR_W + 1;

	localparam longint K_R = ((longint'(K_R_MILLI) << COEFF_FRAC_BITS) + 500) / 1000;
	localparam longint K_G = ((longint'(K_G_MILLI) << COEFF_FRAC_BITS) + 500) / 1000;
	localparam longint K_B = ((longint'(K_B_MILLI) << COEFF_FRAC_BITS) + 500) / 1000;
	localparam longint K_U = ((longint'(K_U_MILLI) << COEFF_FRAC_BITS) + 500) / 1000;
	localparam longint K_V = ((longint'(K_V_MILLI) << COEFF_FRAC_BITS) + 500) / 1000;
	localparam logic signed [B_W-1:0] K_R_B = B_W'(K_R);
	localparam logic signed [B_W-1:0] K_G_B = B_W'(K_G);
	localparam logic signed [B_W-1:0] K_B_B = B_W'(K_B);
	localparam logic signed [B_W-1:0] K_U_B = B_W'(K_U);
	localparam logic signed [B_W-1:0] K_V_B = B_W'(K_V);
	localparam logic signed [P_W:0] C_OFFSET =
		(P_W + 1)'(longint'(CHROMA_OFFSET) << COEFF_FRAC_BITS);

	// Sequencer steps
	localparam logic [3:0] ST_KR    = 4'd0;
	localparam logic [3:0] ST_KG    = 4'd1;
	localparam logic [3:0] ST_KB    = 4'd2;
	localparam logic [3:0] ST_AREA  = 4'd3;
	localparam logic [3:0] ST_CROW  = 4'd4;
	localparam logic [3:0] ST_LUMA  = 4'd5;
	localparam logic [3:0] ST_KU    = 4'd6;
	localparam logic [3:0] ST_KV    = 4'd7;
	localparam logic [3:0] ST_U     = 4'd8;
	localparam logic [3:0] ST_V     = 4'd9;

	// Write slots of one pixel
	localparam logic [1:0] SLOT_Y  = 2'd0;
	localparam logic [1:0] SLOT_C1 = 2'd1;
	localparam logic [1:0] SLOT_C2 = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CALC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	function automatic logic [13:0] eff_size(input logic [SIZE_REG_W-1:0] r,
			input logic [13:0] m);
		logic [13:0] v;
		v = {1'b0, r[SIZE_REG_W-1:2], 2'b00};
		if (v < 14'd4) begin
			v = 14'd4;
		end
		if (v > m) begin
			v = m;
		end
		eff_size = v;
	endfunction

	function automatic logic [7:0] clamp_byte(input logic signed [P_W:0] t);
		logic signed [P_W:0] q;
		q = t >>> COEFF_FRAC_BITS;
		if (t < 0) begin
			clamp_byte = 8'd0;
		end else if (q > 255) begin
			clamp_byte = 8'd255;
		end else begin
			clamp_byte = q[7:0];
		end
	endfunction

	state_t                    state_q;
	logic [3:0]                step_q;
	logic [1:0]                slot_q;
	logic [FMT_W-1:0]          fmt_q;
	logic [SIZE_REG_W-1:0]     width_q;
	logic [SIZE_REG_W-1:0]     height_q;
	logic [CX_W-1:0]           col_q;
	logic [RY_W-1:0]           row_q;
	logic [LUMA_IDX_W-1:0]     luma_q;
	logic [CHROMA_IDX_W-1:0]   chroma_q;
	pixel_t                    pix_q;
	logic signed [P_W-1:0]     prod_s1;
	logic signed [P_W:0]       acc_q;
	logic [7:0]                y_q;
	logic [7:0]                u_q;
	logic [7:0]                v_q;
	logic [AREA_W-1:0]         area_q;
	logic [AREA_W-1:0]         crow_q;
	logic                      mem_valid_q;
	result_t                   mem_q;

	logic [W_W-1:0]            w_eff;
	logic [H_W-1:0]            h_eff;
	logic signed [A_W-1:0]     mul_a;
	logic signed [B_W-1:0]     mul_b;
	logic signed [8:0]         diff_b;
	logic signed [8:0]         diff_r;
	logic                      take_chroma;
	logic                      last_col;
	logic                      last_row;
	logic                      last_slot;
	logic                      load;
	logic                      cfg_hit;
	logic [CALC_W-1:0]         addr_y;
	logic [CALC_W-1:0]         addr_c1;
	logic [CALC_W-1:0]         addr_c2;
	logic [CALC_W-1:0]         area_c;
	logic [CALC_W-1:0]         li_c;
	logic [CALC_W-1:0]         ci_c;
	logic [CALC_W-1:0]         nv_base;
	logic [7:0]                c1_byte;
	logic [7:0]                c2_byte;
	result_t                   next_res;

	assign w_eff = W_W'(eff_size(width_q, 14'(W_MAX)));
	assign h_eff = H_W'(eff_size(height_q, 14'(H_MAX)));

	assign pixel_ready = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign cfg_hit     = cfg_valid && (cfg_index inside {REG_PIXEL_FORMAT,
		REG_FRAME_WIDTH, REG_FRAME_HEIGHT});
	assign mem_valid   = mem_valid_q;
	assign mem         = mem_q;

	assign diff_b = $signed({1'b0, pix_q.blue}) - $signed({1'b0, y_q});
	assign diff_r = $signed({1'b0, pix_q.red}) - $signed({1'b0, y_q});

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_KR: begin
				mul_a = A_W'(pix_q.red);
				mul_b = K_R_B;
			end
			ST_KG: begin
				mul_a = A_W'(pix_q.green);
				mul_b = K_G_B;
			end
			ST_KB: begin
				mul_a = A_W'(pix_q.blue);
				mul_b = K_B_B;
			end
			ST_AREA: begin
				mul_a = A_W'(w_eff);
				mul_b = B_W'(h_eff);
			end
			ST_CROW: begin
				mul_a = A_W'(w_eff);
				mul_b = B_W'(row_q[RY_W-1:1]);
			end
			ST_KU: begin
				mul_a = A_W'(diff_b);
				mul_b = K_U_B;
			end
			ST_KV: begin
				mul_a = A_W'(diff_r);
				mul_b = K_V_B;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign last_col = ((W_W + 1)'(col_q) + 1'b1) >= (W_W + 1)'(w_eff);
	assign last_row = ((H_W + 1)'(row_q) + 1'b1) >= (H_W + 1)'(h_eff);

	always_comb begin
		case (fmt_q)
			FMT_NV12, FMT_NV21, FMT_I420, FMT_YV12: take_chroma = !col_q[0] && !row_q[0];
			FMT_YUYV, FMT_UYVY: take_chroma = !col_q[0];
			default: take_chroma = 1'b1;
		endcase
	end

	assign area_c  = CALC_W'(area_q);
	assign li_c    = CALC_W'(luma_q);
	assign ci_c    = CALC_W'(chroma_q);
	assign nv_base = area_c + CALC_W'(crow_q) + CALC_W'(col_q);

	always_comb begin
		c1_byte = u_q;
		c2_byte = v_q;
		case (fmt_q)
			FMT_NV12, FMT_NV21: begin
				addr_y  = li_c;
				addr_c1 = nv_base;
				addr_c2 = nv_base + 1'b1;
			end
			FMT_I420, FMT_YV12: begin
				addr_y  = li_c;
				addr_c1 = area_c + ci_c;
				addr_c2 = area_c + (area_c >> 2) + ci_c;
			end
			FMT_YUYV: begin
				addr_y  = li_c << 1;
				addr_c1 = (li_c << 1) + 2'd1;
				addr_c2 = (li_c << 1) + 2'd3;
			end
			FMT_UYVY: begin
				addr_y  = (li_c << 1) + 2'd1;
				addr_c1 = li_c << 1;
				addr_c2 = (li_c << 1) + 2'd2;
			end
			default: begin
				addr_y  = li_c;
				addr_c1 = area_c + li_c;
				addr_c2 = (area_c << 1) + li_c;
			end
		endcase
		// V first in these layouts
		if (fmt_q inside {FMT_NV21, FMT_YV12}) begin
			c1_byte = v_q;
			c2_byte = u_q;
		end
	end

	assign last_slot = (slot_q == SLOT_C2) || (slot_q == SLOT_Y && !take_chroma);
	assign load      = (state_q == S_EMIT) && (!mem_valid_q || mem_ready);

	always_comb begin
		case (slot_q)
			SLOT_C1: begin
				next_res.byte_address = addr_c1[ADDR_W-1:0];
				next_res.data_byte    = c1_byte;
			end
			SLOT_C2: begin
				next_res.byte_address = addr_c2[ADDR_W-1:0];
				next_res.data_byte    = c2_byte;
			end
			default: begin
				next_res.byte_address = addr_y[ADDR_W-1:0];
				next_res.data_byte    = y_q;
			end
		endcase
		next_res.last_of_pixel = last_slot;
		next_res.frame_done    = last_slot && last_col && last_row;
	end

	// Payload and datapath registers; each product lands one step after its operands
	always_ff @(posedge clk) begin
		if (pixel_valid && pixel_ready) begin
			pix_q <= pixel;
		end
		if (load) begin
			mem_q <= next_res;
		end
		if (state_q == S_CALC) begin
			case (step_q)
				ST_KG: acc_q <= (P_W + 1)'(prod_s1);
				ST_KB, ST_AREA: acc_q <= acc_q + (P_W + 1)'(prod_s1);
				ST_CROW: area_q <= prod_s1[AREA_W-1:0];
				ST_LUMA: begin
					y_q    <= clamp_byte(acc_q);
					crow_q <= prod_s1[AREA_W-1:0];
				end
				ST_KV: u_q <= clamp_byte((P_W + 1)'(prod_s1) + C_OFFSET);
				ST_U: v_q <= clamp_byte((P_W + 1)'(prod_s1) + C_OFFSET);
				default: acc_q <= acc_q;
			endcase
		end
	end

	// Sequencer, output valid and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_KR;
			slot_q      <= SLOT_Y;
			mem_valid_q <= 1'b0;
			fmt_q       <= RST_PIXEL_FORMAT;
			width_q     <= RST_FRAME_WIDTH;
			height_q    <= RST_FRAME_HEIGHT;
			col_q       <= '0;
			row_q       <= '0;
			luma_q      <= '0;
			chroma_q    <= '0;
		end else begin
			if (load) begin
				mem_valid_q <= 1'b1;
			end else if (mem_ready) begin
				mem_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pixel_valid) begin
						state_q <= S_CALC;
						step_q  <= ST_KR;
					end
				end
				S_CALC: begin
					if (step_q == ST_V) begin
						state_q <= S_EMIT;
						slot_q  <= SLOT_Y;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (last_slot) begin
							state_q <= S_IDLE;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_hit) begin
				// Any register write restarts the frame
				case (cfg_index)
					REG_PIXEL_FORMAT: fmt_q <= cfg_data[FMT_W-1:0];
					REG_FRAME_WIDTH: width_q <= cfg_data;
					default: height_q <= cfg_data;
				endcase
				col_q    <= '0;
				row_q    <= '0;
				luma_q   <= '0;
				chroma_q <= '0;
			end else if (load && last_slot) begin
				if (last_col && last_row) begin
					col_q    <= '0;
					row_q    <= '0;
					luma_q   <= '0;
					chroma_q <= '0;
				end else begin
					if (take_chroma
							&& (fmt_q inside {FMT_NV12, FMT_NV21, FMT_I420, FMT_YV12})) begin
						chroma_q <= chroma_q + 1'b1;
					end
					luma_q <= luma_q + 1'b1;
					if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		mem_valid_q && mem_q.frame_done |-> mem_q.last_of_pixel)
		else $error("frame_done without last_of_pixel");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> col_q == '0 && row_q == '0 && luma_q == '0 && chroma_q == '0)
		else $error("register write did not restart the frame");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(W_W + 1)'(col_q) < (W_W + 1)'(w_eff) && (H_W + 1)'(row_q) < (H_W + 1)'(h_eff))
		else $error("frame position outside the frame");

	a_start_calc: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> state_q == S_CALC && step_q == ST_KR)
		else $error("accepted pixel did not start the sequencer");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> slot_q == SLOT_Y || slot_q == SLOT_C1 || slot_q == SLOT_C2)
		else $error("write slot out of range");
`endif

endmodule
